>>> hdl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int LKV_ENTRIES = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic              CMD_GET    = 1'b0;
    localparam logic              CMD_PUT    = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MATCH,
        OP_TOUCH,
        OP_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic                      evict;
        logic                      wr_data;
        logic signed [KEY_W-1:0]   key;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

>>> hdl/lkv_req_if.sv
// Request channel: command, key and value with valid/ready.
interface lkv_req_if;
    import lkv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

>>> hdl/lkv_rsp_if.sv
// Response channel: found flag and read value with valid/ready.
interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

>>> hdl/lkv_cfg_if.sv
// Configuration write channel carrying the capacity limit.
interface lkv_cfg_if;
    import lkv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

>>> hdl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: slot chain, sequencer and result register.
//
//  Channel   Dir  Payload                     Transaction when
//  i_req     in   cmd, key, value             i_req.valid & i_req.ready
//  o_rsp     out  found, read_value           o_rsp.valid & o_rsp.ready
//  i_cfg     in   capacity_limit              i_cfg.valid & i_cfg.ready (always ready)
//
// Each request passes through accept (ST_IDLE), parallel key compare in every slot
// (ST_LOOKUP), then the recency/insert update (ST_UPDATE), in that order.
// A get whose result register is still occupied and not being read holds in the update state.
// Reset clears valid marks, ages, occupancy and sets the limit to 16.
// A put produces no response transaction.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkv_req_if.sink   i_req,
    lkv_rsp_if.source o_rsp,
    lkv_cfg_if.sink   i_cfg
);
    import lkv_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    t_state                   r_state, n_state;
    logic                     r_cmd;
    logic signed [KEY_W-1:0]  r_key;
    logic signed [DATA_W-1:0] r_value;
    logic [CAP_W-1:0]         r_cap;
    logic [CW-1:0]            r_occ, n_occ;
    logic                     r_out_valid;
    logic                     r_found;
    logic signed [DATA_W-1:0] r_rdata;

    t_cell_ctl                ctl;
    logic [AW-1:0]            ref_age;
    logic [ENTRIES:0]         free_chain;
    logic [ENTRIES-1:0]       hits;
    logic [ENTRIES-1:0]       valids;
    logic [AW-1:0]            ages [ENTRIES];
    logic signed [DATA_W-1:0] datas [ENTRIES];

    logic                     hit_any;
    logic [AW-1:0]            hit_age;
    logic signed [DATA_W-1:0] hit_data;
    logic [LW-1:0]            cap_ext;
    logic [LW-1:0]            lim_full;
    logic [CW-1:0]            lim;
    logic [CW-1:0]            lim_m1;
    logic                     need_evict;
    logic                     go;
    logic                     rsp_load;

    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(.AW(AW)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_ref_age     (ref_age),
            .i_free_before (free_chain[g]),
            .o_free_before (free_chain[g+1]),
            .o_hit         (hits[g]),
            .o_valid       (valids[g]),
            .o_age         (ages[g]),
            .o_data        (datas[g])
        );
    end

    always_comb begin
        hit_age  = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hits[i]) begin
                hit_age  = hit_age | ages[i];
                hit_data = hit_data | datas[i];
            end
        end
    end

    assign hit_any    = |hits;
    assign cap_ext    = LW'(r_cap);
    assign lim_full   = (cap_ext == '0) ? LW'(1) :
                        (cap_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : cap_ext;
    assign lim        = CW'(lim_full);
    assign lim_m1     = lim - CW'(1);
    assign need_evict = (r_occ >= lim);
    assign go         = !((r_cmd == CMD_GET) && r_out_valid && !o_rsp.ready);
    assign rsp_load   = (r_state == ST_UPDATE) && go && (r_cmd == CMD_GET);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl.op      = OP_NONE;
        ctl.evict   = 1'b0;
        ctl.wr_data = 1'b0;
        ctl.key     = r_key;
        ctl.value   = r_value;
        ref_age     = '0;
        n_occ       = r_occ;
        i_req.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_LOOKUP: begin
                ctl.op = OP_MATCH;
            end
            ST_UPDATE: begin
                if (go) begin
                    if (hit_any) begin
                        ctl.op      = OP_TOUCH;
                        ctl.wr_data = (r_cmd == CMD_PUT);
                        ref_age     = hit_age;
                    end else if (r_cmd == CMD_PUT) begin
                        ctl.op    = OP_INSERT;
                        ctl.evict = need_evict;
                        ref_age   = AW'(lim_m1);
                        n_occ     = (need_evict ? lim_m1 : r_occ) + CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.capacity_limit;
            end
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd   <= i_req.cmd;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (rsp_load) begin
            r_found <= hit_any;
            r_rdata <= hit_any ? hit_data : MISS_VALUE;
        end
    end

    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.read_value = r_rdata;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(valids)) == r_occ)
        else $error("occupancy count differs from valid slots");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(ENTRIES))
        else $error("occupancy above slot count");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $onehot0(hits))
        else $error("key present in more than one slot");

    a_get_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_load |=> r_out_valid)
        else $error("get completed without a response");
endmodule

>>> hdl/lkv_cell.sv
// One cache slot: key, data, valid mark and recency age.
module lkv_cell #(
    parameter int AW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_cell_ctl                i_ctl,
    input  logic [AW-1:0]                     i_ref_age,
    input  logic                              i_free_before,
    output logic                              o_free_before,
    output logic                              o_hit,
    output logic                              o_valid,
    output logic [AW-1:0]                     o_age,
    output logic signed [lkv_pkg::DATA_W-1:0] o_data
);
    import lkv_pkg::*;

    logic signed [KEY_W-1:0]  r_key, n_key;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_valid, n_valid;
    logic                     r_hit, n_hit;
    logic [AW-1:0]            r_age, n_age;
    logic                     valid_after;
    logic                     free;
    logic                     take;

    assign valid_after   = r_valid && !(i_ctl.evict && (r_age >= i_ref_age));
    assign free          = !valid_after;
    assign take          = free && !i_free_before;
    assign o_free_before = i_free_before | free;

    always_comb begin
        n_key   = r_key;
        n_data  = r_data;
        n_valid = r_valid;
        n_hit   = r_hit;
        n_age   = r_age;
        case (i_ctl.op)
            OP_MATCH: begin
                n_hit = r_valid && (r_key == i_ctl.key);
            end
            OP_TOUCH: begin
                if (r_hit) begin
                    n_age = '0;
                    if (i_ctl.wr_data) begin
                        n_data = i_ctl.value;
                    end
                end else if (r_valid && (r_age < i_ref_age)) begin
                    n_age = r_age + 1'b1;
                end
            end
            OP_INSERT: begin
                n_valid = valid_after;
                if (valid_after) begin
                    n_age = r_age + 1'b1;
                end else if (take) begin
                    n_key   = i_ctl.key;
                    n_data  = i_ctl.value;
                    n_valid = 1'b1;
                    n_age   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_hit   = r_hit;
    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_data  = r_data;
endmodule

>>> tb/tb.sv
// Self-checking testbench for the LRU key-value cache: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb;
    import lkv_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_COUNT     = 6;
    localparam int SEG_ITEMS     = 213;
    localparam int POOL_SIZE     = 24;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] read_value;
    } t_lookup;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic              typed;
        t_lookup           result;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();
    lkv_cfg_if cfg_if ();

    lru_key_value_cache #(
        .ENTRIES(LKV_ENTRIES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [KEY_W-1:0]  slot_key   [LKV_ENTRIES];
    logic [DATA_W-1:0] slot_data  [LKV_ENTRIES];
    bit                slot_valid [LKV_ENTRIES] = '{default: 1'b0};
    logic [3:0]        slot_age   [LKV_ENTRIES] = '{default: 4'd0};
    logic [CAP_W-1:0]  occupied   = '0;
    logic [CAP_W-1:0]  limit_reg  = CAP_RESET;

    t_lookup pending_lookups [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      req_gap_pct    = 0;
    int      rsp_stall_pct  = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               seg_limit [SEG_COUNT] = '{1, 16, 0, 31, 7, 3};

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
        '{ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h8000_0000}},
        '{ROW_REQ, CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
        '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000}},
        '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h1234_5678, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_PUT, 32'h0000_0007, 32'h0000_0077, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_PUT, 32'h0000_0008, 32'h0000_0088, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}},
        '{ROW_REQ, CMD_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, '{1'b0, MISS_VALUE}}
    };

    function automatic void promote_slot(input int s);
        logic [3:0] a;
        int         i;
        a = slot_age[s];
        for (i = 0; i < LKV_ENTRIES; i++) begin
            if (slot_valid[i] && slot_age[i] < a) begin
                slot_age[i] = slot_age[i] + 4'd1;
            end
        end
        slot_age[s] = 4'd0;
    endfunction

    function automatic void cache_access(input logic cmd, input logic [KEY_W-1:0] key,
                                         input logic [DATA_W-1:0] value,
                                         output bit has_result, output t_lookup res);
        int               hit_slot;
        int               free_slot;
        int               i;
        logic [CAP_W-1:0] eff;
        hit_slot   = -1;
        free_slot  = -1;
        eff        = (limit_reg == 0) ? CAP_W'(1) :
                     (limit_reg > LKV_ENTRIES) ? CAP_W'(LKV_ENTRIES) : limit_reg;
        res.found      = 1'b0;
        res.read_value = MISS_VALUE;
        has_result     = (cmd == CMD_GET);
        for (i = 0; i < LKV_ENTRIES; i++) begin
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) begin
                hit_slot = i;
            end
        end
        if (cmd == CMD_GET) begin
            if (hit_slot >= 0) begin
                res.found      = 1'b1;
                res.read_value = slot_data[hit_slot];
                promote_slot(hit_slot);
            end
        end else if (hit_slot >= 0) begin
            slot_data[hit_slot] = value;
            promote_slot(hit_slot);
        end else begin
            // evict every slot at or past the limit's oldest rank
            if (occupied >= eff) begin
                for (i = 0; i < LKV_ENTRIES; i++) begin
                    if (slot_valid[i] && slot_age[i] >= eff - 1) begin
                        slot_valid[i] = 1'b0;
                    end
                end
                occupied = eff - CAP_W'(1);
            end
            for (i = 0; i < LKV_ENTRIES; i++) begin
                if (slot_valid[i]) begin
                    slot_age[i] = slot_age[i] + 4'd1;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                slot_key[free_slot]   = key;
                slot_data[free_slot]  = value;
                slot_valid[free_slot] = 1'b1;
                slot_age[free_slot]   = 4'd0;
                occupied              = occupied + CAP_W'(1);
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %0d at cycle %0d: %s expected %h got %h",
                     mismatch_count, cycle_count, what, want, got);
        end
    endfunction

    task automatic issue_request(input logic cmd, input logic [KEY_W-1:0] key,
                                 input logic [DATA_W-1:0] value, input logic typed,
                                 input t_lookup typed_res);
        t_lookup predicted;
        bit      has_result;
        while ($urandom_range(99) < req_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.key   <= key;
        req_if.value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        cache_access(cmd, key, value, has_result, predicted);
        if (has_result) begin
            pending_lookups.push_back(typed ? typed_res : predicted);
        end
    endtask

    task automatic settle_cache();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CAP_W-1:0] lim);
        settle_cache();
        cfg_if.valid          <= 1'b1;
        cfg_if.capacity_limit <= lim;
        do @(posedge i_clk); while (!cfg_if.ready);
        limit_reg = lim;
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_lookup want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_lookups.size() == 0) begin
                note_mismatch("unexpected transaction, read_value", MISS_VALUE,
                              rsp_if.read_value);
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_if.found !== want.found) begin
                    note_mismatch("found", DATA_W'(want.found), DATA_W'(rsp_if.found));
                end
                if (rsp_if.read_value !== want.read_value) begin
                    note_mismatch("read_value", want.read_value, rsp_if.read_value);
                end
            end
        end
    end

    initial begin
        logic             cmd;
        logic [KEY_W-1:0] key;
        int               pool_span;
        int               seg;
        int               n;

        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.cmd            <= CMD_GET;
        req_if.key            <= '0;
        req_if.value          <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.capacity_limit <= CAP_RESET;

        for (n = 0; n < POOL_SIZE; n++) begin
            key_pool[n] = $urandom;
        end
        seg_limit[4] = $urandom_range(2, 15);

        req_gap_pct   = 7;
        rsp_stall_pct = 79;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                write_limit(directed_rows[n].value[CAP_W-1:0]);
            end else begin
                issue_request(directed_rows[n].cmd, directed_rows[n].key,
                              directed_rows[n].value, directed_rows[n].typed,
                              directed_rows[n].result);
            end
        end

        for (seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg / 2)
                0: begin
                    req_gap_pct   = 7;
                    rsp_stall_pct = 79;
                end
                1: begin
                    req_gap_pct   = 79;
                    rsp_stall_pct = 7;
                end
                default: begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            write_limit(CAP_W'(seg_limit[seg]));
            pool_span = $urandom_range(4, POOL_SIZE);
            for (n = 0; n < SEG_ITEMS; n++) begin
                cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
                key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_span - 1)]
                                                : KEY_W'($urandom);
                issue_request(cmd, key, DATA_W'($urandom), 1'b0, '0);
                if ($urandom_range(199) == 0) begin
                    settle_cache();
                end
            end
        end

        settle_cache();
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lkv_pkg.sv
hdl/lkv_req_if.sv
hdl/lkv_rsp_if.sv
hdl/lkv_cfg_if.sv
hdl/lkv_cell.sv
hdl/lru_key_value_cache.sv
tb/tb.sv
